### hw/rtl/dpl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpl_pkg
// Shared types and constants of the drum pattern looper.
// ----------------------------------------------------------------------------
package dpl_pkg;

  localparam int GAP_W  = 16;
  localparam int MASK_W = 3;
  localparam int TICK_W = 32;
  localparam int MODE_W = 2;

  // mask stored in the closing entry of a pattern
  localparam logic [MASK_W-1:0] SILENT_MASK = 3'b000;

  // mode codes as seen on the result
  localparam logic [MODE_W-1:0] MODE_CODE_OFF    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CODE_PLAY   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CODE_RECORD = 2'd2;

  // command codes of an input item
  typedef enum logic [1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_TOGGLE = 2'd1,
    FUNC_RECORD = 2'd2,
    FUNC_STOP   = 2'd3
  } func_t;

  // looper mode, one-hot
  typedef enum logic [2:0] {
    MODE_OFF    = 3'b001,
    MODE_PLAY   = 3'b010,
    MODE_RECORD = 3'b100
  } mode_t;

  // one pattern entry: gap before the hit, and the hit mask
  typedef struct packed {
    logic [GAP_W-1:0]  gap;
    logic [MASK_W-1:0] mask;
  } entry_t;

  // one result item
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [MASK_W-1:0] trigger_mask;
  } result_t;

  function automatic logic [MODE_W-1:0] mode_code(input mode_t m);
    logic [MODE_W-1:0] code;
    unique case (m)
      MODE_PLAY:   code = MODE_CODE_PLAY;
      MODE_RECORD: code = MODE_CODE_RECORD;
      default:     code = MODE_CODE_OFF;
    endcase
    return code;
  endfunction

endpackage

### hw/rtl/drum_pattern_looper_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drum_pattern_looper_unit
// Records a drum pattern as (gap, hit mask) entries and replays it in a loop.
// ----------------------------------------------------------------------------
// The looper takes one item per clock and returns one result per item,
// registered through a two-entry output queue; s_tready is low in reset and
// otherwise drops only while that queue holds two results not yet taken.
// Pattern entries live
// in a LOOP_DEPTH-entry RAM with a registered read port: the entry for the
// next slot is fetched in the cycle that the current item updates the slot
// pointer, so it is ready when the following item arrives, and a write to the
// same entry in that cycle is forwarded. The closing (silent) entry of a
// pattern is kept in registers rather than in the RAM. The store needs no
// clearing pass after reset; entries not yet recorded read as undefined.
module drum_pattern_looper_unit #(
  parameter int LOOP_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [1:0] func, [4:2] hits, [7:5] zero
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [2:0] trigger_mask, [4:3] mode, [7:5] zero
);

  localparam int IDX_W = $clog2(LOOP_DEPTH);
  localparam int LEN_W = $clog2(LOOP_DEPTH + 1);
  localparam logic [LEN_W-1:0] LEN_FULL  = LEN_W'(LOOP_DEPTH);
  localparam logic [LEN_W-1:0] LEN_CLOSE = LEN_W'(LOOP_DEPTH - 1);

  // input decode
  dpl_pkg::func_t               func;
  logic [dpl_pkg::MASK_W-1:0]   hits;
  logic                         s_fire;

  assign func   = dpl_pkg::func_t'(s_tdata[1:0]);
  assign hits   = s_tdata[4:2];
  assign s_fire = s_tvalid && s_tready;

  // looper state
  dpl_pkg::mode_t               mode, mode_next;
  logic [dpl_pkg::TICK_W-1:0]   elapsed, elapsed_next;
  logic [IDX_W-1:0]             slot, slot_next;
  logic [LEN_W-1:0]             pattern_length, pattern_length_next;
  logic [dpl_pkg::GAP_W-1:0]    tail_gap, tail_gap_next;
  logic                         tail_live, tail_live_next;

  // RAM port and forwarding
  logic                         we;
  logic [IDX_W-1:0]             waddr;
  dpl_pkg::entry_t              wr_entry;
  dpl_pkg::entry_t              ram_q;
  logic                         fwd_hit;
  dpl_pkg::entry_t              fwd_entry;
  dpl_pkg::entry_t              cur_entry;

  // per-item results
  logic [dpl_pkg::MASK_W-1:0]   fire_mask;
  logic [LEN_W-1:0]             slot_inc;
  logic                         tail_hit;
  dpl_pkg::result_t             res;
  dpl_pkg::result_t             q_data;
  logic                         q_full;

  dpl_ram #(
    .WIDTH ($bits(dpl_pkg::entry_t)),
    .DEPTH (LOOP_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wr_entry),
    .raddr (slot_next),
    .rdata (ram_q)
  );

  // current entry: closing entry from registers, else forwarded or RAM data
  assign slot_inc = LEN_W'(slot) + LEN_W'(1);
  assign tail_hit = tail_live && (slot_inc == pattern_length);

  always_comb begin
    if (tail_hit) begin
      cur_entry.gap  = tail_gap;
      cur_entry.mask = dpl_pkg::SILENT_MASK;
    end else if (fwd_hit) begin
      cur_entry = fwd_entry;
    end else begin
      cur_entry = ram_q;
    end
  end

  // item processing
  always_comb begin
    mode_next           = mode;
    elapsed_next        = elapsed;
    slot_next           = slot;
    pattern_length_next = pattern_length;
    tail_gap_next       = tail_gap;
    tail_live_next      = tail_live;
    we                  = 1'b0;
    waddr               = slot;
    wr_entry.gap        = elapsed[dpl_pkg::GAP_W-1:0];
    wr_entry.mask       = hits;
    fire_mask           = '0;

    if (s_fire) begin
      unique case (func)
        dpl_pkg::FUNC_TICK: begin
          if (mode == dpl_pkg::MODE_PLAY && pattern_length != '0) begin
            if (elapsed >= dpl_pkg::TICK_W'(cur_entry.gap)) begin
              fire_mask    = cur_entry.mask;
              slot_next    = (slot_inc >= pattern_length) ? '0 : slot + IDX_W'(1);
              elapsed_next = '0;
            end else begin
              elapsed_next = elapsed + dpl_pkg::TICK_W'(1);
            end
          end else if (mode == dpl_pkg::MODE_RECORD) begin
            if (hits != '0 && slot_inc < LEN_FULL) begin
              we           = 1'b1;
              elapsed_next = '0;
              // a hit over the old closing slot replaces it
              if (slot_inc == pattern_length) begin
                tail_live_next = 1'b0;
              end
              if (slot_inc == LEN_CLOSE) begin
                // store full: close loop, closing gap equals this gap
                tail_gap_next       = elapsed[dpl_pkg::GAP_W-1:0];
                tail_live_next      = 1'b1;
                pattern_length_next = LEN_FULL;
                mode_next           = dpl_pkg::MODE_PLAY;
                slot_next           = '0;
              end else begin
                slot_next = slot + IDX_W'(1);
              end
            end else begin
              elapsed_next = elapsed + dpl_pkg::TICK_W'(1);
            end
          end
        end
        dpl_pkg::FUNC_TOGGLE: begin
          elapsed_next = '0;
          slot_next    = '0;
          unique case (mode)
            dpl_pkg::MODE_PLAY: begin
              mode_next = dpl_pkg::MODE_OFF;
            end
            dpl_pkg::MODE_RECORD: begin
              // finish recording with the trailing gap
              tail_gap_next       = elapsed[dpl_pkg::GAP_W-1:0];
              tail_live_next      = 1'b1;
              pattern_length_next = slot_inc;
              mode_next           = dpl_pkg::MODE_PLAY;
            end
            default: begin
              mode_next = dpl_pkg::MODE_PLAY;
            end
          endcase
        end
        dpl_pkg::FUNC_RECORD: begin
          elapsed_next = '0;
          slot_next    = '0;
          mode_next    = dpl_pkg::MODE_RECORD;
        end
        default: begin
          elapsed_next = '0;
          slot_next    = '0;
          mode_next    = dpl_pkg::MODE_OFF;
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= dpl_pkg::MODE_OFF;
      elapsed        <= '0;
      slot           <= '0;
      pattern_length <= '0;
      tail_live      <= 1'b0;
      fwd_hit        <= 1'b0;
    end else begin
      mode           <= mode_next;
      elapsed        <= elapsed_next;
      slot           <= slot_next;
      pattern_length <= pattern_length_next;
      tail_live      <= tail_live_next;
      fwd_hit        <= we && (waddr == slot_next);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    tail_gap  <= tail_gap_next;
    fwd_entry <= wr_entry;
  end

  // result queue
  assign res.trigger_mask = fire_mask;
  assign res.mode         = dpl_pkg::mode_code(mode_next);
  assign s_tready         = !q_full && !rst;

  dpl_out_q u_out_q (
    .clk       (clk),
    .rst       (rst),
    .push      (s_fire),
    .push_data (res),
    .full      (q_full),
    .valid     (m_tvalid),
    .ready     (m_tready),
    .data      (q_data)
  );

  assign m_tdata = {3'b000, q_data.mode, q_data.trigger_mask};

  // checks
  a_fire_only_in_play: assert property (@(posedge clk) disable iff (rst)
    (s_fire && fire_mask != '0) |-> (mode == dpl_pkg::MODE_PLAY))
    else $error("trigger outside play mode");

  a_slot_in_pattern: assert property (@(posedge clk) disable iff (rst)
    (mode == dpl_pkg::MODE_PLAY && pattern_length != '0) |-> (slot_inc <= pattern_length))
    else $error("play slot beyond pattern length");

  a_record_slot_room: assert property (@(posedge clk) disable iff (rst)
    (mode == dpl_pkg::MODE_RECORD) |-> (slot_inc < LEN_FULL))
    else $error("record slot past closing slot");

  a_tail_has_pattern: assert property (@(posedge clk) disable iff (rst)
    tail_live |-> (pattern_length != '0))
    else $error("closing entry without a pattern");

  a_stall_only_when_pending: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with no result pending");

endmodule

### hw/rtl/dpl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpl_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dpl_ram #(
  parameter int WIDTH = 19,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/dpl_out_q.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpl_out_q
// Two-entry result queue that decouples the output side from the input side.
// ----------------------------------------------------------------------------
module dpl_out_q (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  dpl_pkg::result_t push_data,
  output logic             full,
  output logic             valid,
  input  logic             ready,
  output dpl_pkg::result_t data
);

  dpl_pkg::result_t entries [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             pop;

  assign pop   = valid && ready;
  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign data  = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule
